### hdl/dpd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the dock presence pulse detector.
// No dependencies; imported by dpd_next_state and the top level.
package dpd_pkg;

    localparam int TIMER_BITS  = 16;
    localparam int TIMEOUT_W   = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 8;

    localparam logic [32:0] TMASK = (33'd1 << TIMER_BITS) - 33'd1;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_CHARGE = 2'd1,
        ACT_EDGE   = 2'd2,
        ACT_MOTION = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMEOUT = 2'd0,
        REG_LEGACY  = 2'd1,
        REG_GATING  = 2'd2,
        REG_HOLD_DIS = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout;
        logic                 legacy_hw;
        logic                 motion_gating;
        logic                 hold_disable;
    } cfg_t;

    typedef struct packed {
        logic                  docked;
        logic                  reported;
        logic                  moving;
        logic                  armed;
        logic [TIMER_BITS-1:0] count;
        logic                  edge_watch;
        logic                  hold;
        logic                  tracking;
    } dock_state_t;

    typedef struct packed {
        action_t action;
        logic    charge;
        logic    detect;
        logic    motion;
    } dock_item_t;

    // Reload value: zero counts as one tick, larger than the counter saturates.
    function automatic logic [TIMER_BITS-1:0] arm_value(input logic [TIMEOUT_W-1:0] t);
        logic [32:0] w;
        w = 33'(t);
        if (w == 33'd0) begin
            w = 33'd1;
        end
        if (w > TMASK) begin
            w = TMASK;
        end
        return w[TIMER_BITS-1:0];
    endfunction

endpackage

### hdl/dock_presence_pulse_detector_core.sv
`timescale 1ns / 1ps
// Top level of the dock presence pulse detector: config registers, state and
// result register around dpd_next_state. Depends on dpd_pkg, dpd_next_state.

// One word in, one result word out. The whole update
// (flag logic plus one TIMER_BITS-wide down-counter) sits between the input
// handshake and the result register, so a new word is taken every cycle while
// the result register is empty or being drained in the same cycle. Every word,
// including ticks and ignored events, yields exactly one result word that
// shows the state after it. Configuration writes take effect at the next edge.
module dock_presence_pulse_detector_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [dpd_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [dpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // action[1:0], charge_level[2], detect_level[3], motion_level[4], zeros
    input  logic [dpd_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // online[0], raw_docked[1], report_changed[2], pulse_hold[3],
    // edge_watch[4], motion_tracking[5], zeros
    output logic [dpd_pkg::M_TDATA_W-1:0]   m_tdata
);
    import dpd_pkg::*;

    cfg_t                 cfg_reg;
    dock_state_t          st_reg;
    dock_state_t          st_next;
    dock_item_t           item;
    logic                 changed;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 s_accept;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

    assign item.action = action_t'(s_tdata[1:0]);
    assign item.charge = s_tdata[2];
    assign item.detect = s_tdata[3];
    assign item.motion = s_tdata[4];

    dpd_next_state u_next (
        .st      (st_reg),
        .cfg     (cfg_reg),
        .item    (item),
        .nx      (st_next),
        .changed (changed)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout       <= TIMEOUT_W'(1000);
            cfg_reg.legacy_hw     <= 1'b0;
            cfg_reg.motion_gating <= 1'b0;
            cfg_reg.hold_disable  <= 1'b0;
            st_reg.docked         <= 1'b0;
            st_reg.reported       <= 1'b0;
            st_reg.moving         <= 1'b0;
            st_reg.armed          <= 1'b0;
            st_reg.count          <= '0;
            st_reg.edge_watch     <= 1'b1;
            st_reg.hold           <= 1'b0;
            st_reg.tracking       <= 1'b0;
            m_valid_reg           <= 1'b0;
        end else begin
            if (s_accept) begin
                st_reg <= st_next;
            end
            if (cfg_we) begin
                unique case (cfg_idx_t'(cfg_addr))
                    REG_TIMEOUT:  cfg_reg.timeout <= cfg_wdata[TIMEOUT_W-1:0];
                    REG_LEGACY: begin
                        cfg_reg.legacy_hw <= cfg_wdata[0];
                        st_reg.edge_watch <= !cfg_wdata[0];
                    end
                    REG_GATING:   cfg_reg.motion_gating <= cfg_wdata[0];
                    REG_HOLD_DIS: cfg_reg.hold_disable  <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {2'b00, st_next.tracking, st_next.edge_watch, st_next.hold,
                            changed, st_next.docked, st_next.reported};
        end
    end

`ifndef SYNTHESIS
    a_armed_count: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.armed |-> (st_reg.count != '0))
        else $error("timer armed with zero count");

    a_changed_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (m_tdata_reg[2] == (st_reg.reported != $past(st_reg.reported))))
        else $error("report_changed does not match reported state");

    a_charge_disarm: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !cfg_we && item.action == ACT_CHARGE && item.charge)
        |=> (!st_reg.armed && !st_reg.edge_watch && !st_reg.hold && st_reg.docked))
        else $error("charge high did not disarm and dock");

    a_result_mirror: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (m_tdata_reg[0] == st_reg.reported && m_tdata_reg[1] == st_reg.docked))
        else $error("result word out of step with state");
`endif

endmodule

### hdl/dpd_next_state.sv
`timescale 1ns / 1ps
// Next-state logic for one word: line detection, timer, motion gating, report.
// Depends on dpd_pkg.
module dpd_next_state (
    input  dpd_pkg::dock_state_t st,
    input  dpd_pkg::cfg_t        cfg,
    input  dpd_pkg::dock_item_t  item,
    output dpd_pkg::dock_state_t nx,
    output logic                 changed
);
    import dpd_pkg::*;

    logic                  set_req;
    logic                  set_val;
    logic                  pub_req;
    logic                  pub_val;
    logic [TIMER_BITS-1:0] cnt_dec;

    assign cnt_dec = st.count - TIMER_BITS'(1);

    always_comb begin
        nx      = st;
        changed = 1'b0;
        set_req = 1'b0;
        set_val = 1'b0;
        pub_req = 1'b0;
        pub_val = 1'b0;

        unique case (item.action)
            ACT_TICK: begin
                if (st.armed) begin
                    nx.count = cnt_dec;
                    if (cnt_dec == '0) begin
                        nx.armed = 1'b0;
                        nx.hold  = 1'b0;
                        set_req  = 1'b1;
                        set_val  = 1'b0;
                    end
                end
            end
            ACT_CHARGE: begin
                if (item.charge) begin
                    nx.edge_watch = 1'b0;
                    nx.hold       = 1'b0;
                    nx.armed      = 1'b0;
                    nx.count      = '0;
                    set_req       = 1'b1;
                    set_val       = 1'b1;
                end else if (!cfg.legacy_hw) begin
                    if (!cfg.hold_disable) begin
                        nx.hold = 1'b1;
                    end
                    nx.edge_watch = 1'b1;
                    if (!item.detect) begin
                        nx.count = arm_value(cfg.timeout);
                        nx.armed = 1'b1;
                    end
                end else begin
                    set_req = 1'b1;
                    set_val = 1'b0;
                end
            end
            ACT_EDGE: begin
                if (st.edge_watch) begin
                    // a pulse inside the window confirms the dock
                    if (st.armed) begin
                        set_req = 1'b1;
                        set_val = 1'b1;
                    end
                    nx.count = arm_value(cfg.timeout);
                    nx.armed = 1'b1;
                    if (!cfg.hold_disable) begin
                        nx.hold = 1'b1;
                    end
                end
            end
            ACT_MOTION: begin
                if (st.tracking) begin
                    nx.moving = item.motion;
                    if (item.motion && !st.docked) begin
                        pub_req = 1'b1;
                        pub_val = 1'b0;
                    end
                end
            end
            default: ;
        endcase

        if (set_req && (st.docked != set_val)) begin
            nx.docked = set_val;
            // gated undock waits for motion
            if (!cfg.motion_gating || set_val || nx.moving) begin
                pub_req = 1'b1;
                pub_val = set_val;
            end
        end

        if (pub_req && (st.reported != pub_val)) begin
            nx.reported = pub_val;
            changed     = 1'b1;
            if (cfg.motion_gating) begin
                if (pub_val) begin
                    nx.tracking = 1'b1;
                    nx.moving   = item.motion;
                end else begin
                    nx.tracking = 1'b0;
                end
            end
        end
    end

endmodule
